>>> rtl/sfpd_pkg.sv
package sfpd_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 2'd1;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_FRAME_END = 1'b1;

    typedef struct packed {
        logic              item_kind;
        logic [BYTE_W-1:0] payload_value;
        logic [BYTE_W-1:0] payload_index;
        logic [BYTE_W-1:0] frame_descriptor;
        logic [BYTE_W-1:0] frame_length;
        logic              check_ok;
    } t_result;

endpackage

>>> rtl/sfpd_parser.sv
module sfpd_parser (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  logic [sfpd_pkg::BYTE_W-1:0]  i_byte,
    input  logic [sfpd_pkg::BYTE_W-1:0]  i_sync_first,
    input  logic [sfpd_pkg::BYTE_W-1:0]  i_sync_second,
    output logic                         o_res_valid,
    output sfpd_pkg::t_result            o_res
);

    typedef enum logic [2:0] {
        PH_HUNT1 = 3'd0,
        PH_HUNT2 = 3'd1,
        PH_DESC  = 3'd2,
        PH_LEN   = 3'd3,
        PH_DATA  = 3'd4,
        PH_CHK1  = 3'd5,
        PH_CHK2  = 3'd6
    } t_phase;

    t_phase                       r_phase, n_phase;
    logic [sfpd_pkg::BYTE_W-1:0]  r_desc, n_desc;
    logic [sfpd_pkg::BYTE_W-1:0]  r_len, n_len;
    logic [sfpd_pkg::BYTE_W-1:0]  r_cnt, n_cnt;
    logic [sfpd_pkg::BYTE_W-1:0]  r_sum_lo, n_sum_lo;
    logic [sfpd_pkg::BYTE_W-1:0]  r_sum_hi, n_sum_hi;
    logic [sfpd_pkg::BYTE_W-1:0]  r_chk1, n_chk1;
    logic [sfpd_pkg::BYTE_W-1:0]  cnt_inc;
    logic [sfpd_pkg::BYTE_W-1:0]  add_lo;

    always_comb begin
        n_phase     = r_phase;
        n_desc      = r_desc;
        n_len       = r_len;
        n_cnt       = r_cnt;
        n_sum_lo    = r_sum_lo;
        n_sum_hi    = r_sum_hi;
        n_chk1      = r_chk1;
        cnt_inc     = r_cnt + 8'd1;
        add_lo      = r_sum_lo + i_byte;
        o_res_valid = 1'b0;
        o_res.item_kind        = sfpd_pkg::KIND_PAYLOAD;
        o_res.payload_value    = '0;
        o_res.payload_index    = '0;
        o_res.frame_descriptor = r_desc;
        o_res.frame_length     = r_len;
        o_res.check_ok         = 1'b0;

        unique case (r_phase)
            PH_HUNT2: begin
                n_phase = (i_byte == i_sync_second) ? PH_DESC : PH_HUNT1;
            end
            PH_DESC: begin
                n_desc   = i_byte;
                n_sum_lo = i_byte;
                n_sum_hi = i_byte;
                n_phase  = PH_LEN;
            end
            PH_LEN: begin
                n_len    = i_byte;
                n_sum_lo = add_lo;
                n_sum_hi = r_sum_hi + add_lo;
                n_cnt    = '0;
                n_phase  = (i_byte == 8'd0) ? PH_CHK1 : PH_DATA;
            end
            PH_DATA: begin
                n_sum_lo            = add_lo;
                n_sum_hi            = r_sum_hi + add_lo;
                o_res_valid         = i_push;
                o_res.payload_value = i_byte;
                o_res.payload_index = r_cnt;
                if (cnt_inc >= r_len) begin
                    n_cnt   = '0;
                    n_phase = PH_CHK1;
                end else begin
                    n_cnt = cnt_inc;
                end
            end
            PH_CHK1: begin
                n_chk1  = i_byte;
                n_phase = PH_CHK2;
            end
            PH_CHK2: begin
                o_res_valid     = i_push;
                o_res.item_kind = sfpd_pkg::KIND_FRAME_END;
                o_res.check_ok  = (r_chk1 == r_sum_lo) && (i_byte == r_sum_hi);
                n_cnt           = '0;
                n_phase         = PH_HUNT1;
            end
            default: begin
                n_phase = (i_byte == i_sync_first) ? PH_HUNT2 : PH_HUNT1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HUNT1;
            r_desc   <= '0;
            r_len    <= '0;
            r_cnt    <= '0;
            r_sum_lo <= '0;
            r_sum_hi <= '0;
            r_chk1   <= '0;
        end else if (i_push) begin
            r_phase  <= n_phase;
            r_desc   <= n_desc;
            r_len    <= n_len;
            r_cnt    <= n_cnt;
            r_sum_lo <= n_sum_lo;
            r_sum_hi <= n_sum_hi;
            r_chk1   <= n_chk1;
        end
    end

endmodule

>>> rtl/sfpd_out_buf.sv
module sfpd_out_buf (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  sfpd_pkg::t_result  i_data,
    output logic               o_room,
    output logic               o_valid,
    input  logic               i_ready,
    output sfpd_pkg::t_result  o_data
);

    logic               r_out_valid;
    logic               r_skid_valid;
    sfpd_pkg::t_result  r_out;
    sfpd_pkg::t_result  r_skid;
    logic               pop;

    assign pop     = r_out_valid && i_ready;
    assign o_room  = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (!r_out_valid || pop) begin
                r_out       <= i_data;
                r_out_valid <= 1'b1;
            end else begin
                r_skid       <= i_data;
                r_skid_valid <= 1'b1;
            end
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

endmodule

>>> rtl/sync_framed_packet_deframer.sv
// Sync-framed packet deframer with a Fletcher-style checksum. One received byte
// is taken per transfer, and a byte can be accepted in every clock cycle: the
// parser updates its phase, counters and running sums in the same cycle, and
// results go through a two-entry output stage, so input stalls only when two
// results are waiting downstream. Each payload byte comes out with its index;
// after the second check byte one frame-end result carries descriptor, length
// and the checksum verdict. A zero length goes straight to the check bytes. Sync
// values are set through the write port and should be changed only while idle.
module sync_framed_packet_deframer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [sfpd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sfpd_pkg::BYTE_W-1:0]     i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [sfpd_pkg::BYTE_W-1:0]     i_rx_byte,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_item_kind,
    output logic [sfpd_pkg::BYTE_W-1:0]     o_payload_value,
    output logic [sfpd_pkg::BYTE_W-1:0]     o_payload_index,
    output logic [sfpd_pkg::BYTE_W-1:0]     o_frame_descriptor,
    output logic [sfpd_pkg::BYTE_W-1:0]     o_frame_length,
    output logic                            o_check_ok
);

    logic [sfpd_pkg::BYTE_W-1:0]  r_sync_first;
    logic [sfpd_pkg::BYTE_W-1:0]  r_sync_second;
    logic                         push;
    logic                         res_valid;
    sfpd_pkg::t_result            res;
    sfpd_pkg::t_result            out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_first  <= '0;
            r_sync_second <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                sfpd_pkg::CFG_SYNC_FIRST:  r_sync_first  <= i_cfg_data;
                sfpd_pkg::CFG_SYNC_SECOND: r_sync_second <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign push = i_in_valid && o_in_ready;

    sfpd_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_byte        (i_rx_byte),
        .i_sync_first  (r_sync_first),
        .i_sync_second (r_sync_second),
        .o_res_valid   (res_valid),
        .o_res         (res)
    );

    sfpd_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  (res),
        .o_room  (o_in_ready),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (out_data)
    );

    assign o_item_kind        = out_data.item_kind;
    assign o_payload_value    = out_data.payload_value;
    assign o_payload_index    = out_data.payload_index;
    assign o_frame_descriptor = out_data.frame_descriptor;
    assign o_frame_length     = out_data.frame_length;
    assign o_check_ok         = out_data.check_ok;

    a_res_reaches_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |=> o_out_valid)
        else $error("result lost on its way to the output");

    a_full_means_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("skid entry held with empty output register");

    a_ok_only_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_item_kind == sfpd_pkg::KIND_PAYLOAD)) |-> !o_check_ok)
        else $error("verdict set on a payload result");

endmodule
